FILE: sv/gmps_pkg.sv
package gmps_pkg;

  localparam int MAX_COLS  = 64;
  localparam int MAX_ROWS  = 64;
  localparam int COST_BITS = 16;

  // fixed field widths
  localparam int CELL_BITS = 16;
  localparam int SUM_BITS  = 23;
  localparam int CFG_BITS  = 7;
  localparam int CFG_IDX_BITS = 2;

  localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COLS_W    = $clog2(MAX_COLS + 1);
  localparam int ROWS_W    = $clog2(MAX_ROWS + 1);

  localparam int RESET_COLS = (64 > MAX_COLS) ? MAX_COLS : 64;
  localparam int RESET_ROWS = (64 > MAX_ROWS) ? MAX_ROWS : 64;

  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_COLS = 2'd0,
    REG_GRID_ROWS = 2'd1
  } cfg_reg_t;

endpackage

FILE: sv/grid_min_path_sum.sv
// minimum right/down path cost over a streamed grid, one result per cell
// an accepted cell passes through stage 1 and then the output register, which holds it
//   while the output is stalled
// throughput: one cell per cycle unless the output stalls; the row memory entry is read
//   at accept, written back when the cell leaves stage 1, forwarded for single-column grids
// reset (sync, active low): grid size returns to 64 x 64, position restarts at the origin,
//   pipeline empties; the row memory is not cleared (row 0 always fills it first)
module grid_min_path_sum (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gmps_pkg::CELL_BITS-1:0]      in_cell_cost,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gmps_pkg::SUM_BITS-1:0]       out_path_cost,
  output logic                                out_is_final,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gmps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [gmps_pkg::CFG_BITS-1:0]       cfg_data
);
  import gmps_pkg::*;

  logic [SUM_BITS-1:0] row_mem [MAX_COLS];

  logic [COLS_W-1:0]   cols_r;
  logic [ROWS_W-1:0]   rows_r;
  logic [COL_BITS-1:0] col_r;
  logic [ROW_BITS-1:0] row_r;

  logic                s1_valid_r;
  logic [COST_BITS-1:0] s1_cost_r;
  logic [COL_BITS-1:0] s1_col_r;
  logic                s1_first_row_r;
  logic                s1_first_col_r;
  logic                s1_final_r;
  logic [SUM_BITS-1:0] rd_data_r;
  logic                fwd_r;
  logic [SUM_BITS-1:0] fwd_data_r;
  logic [SUM_BITS-1:0] left_r;

  logic                out_valid_r;
  logic [SUM_BITS-1:0] out_sum_r;
  logic                out_final_r;

  logic                in_acc;
  logic                s1_adv;
  logic                cfg_acc;
  logic                cfg_restart;
  logic                last_col;
  logic                last_row;
  logic [SUM_BITS-1:0] up_cost;
  logic [SUM_BITS-1:0] base_cost;
  logic [SUM_BITS:0]   sum_wide;
  logic [SUM_BITS-1:0] sum;

  function automatic logic [31:0] clamp_size(input logic [CFG_BITS-1:0] v, input int limit);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'd1) return 32'd1;
    if (w > 32'(limit)) return 32'(limit);
    return w;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  // only writes to a real register restart the grid
  assign cfg_restart = cfg_acc & ((cfg_index == REG_GRID_COLS) |
                                  (cfg_index == REG_GRID_ROWS));

  assign s1_adv   = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~s1_adv;
  assign in_acc   = in_valid & ~in_stall;

  assign last_col = (COLS_W'(col_r) + COLS_W'(1)) == cols_r;
  assign last_row = (ROWS_W'(row_r) + ROWS_W'(1)) == rows_r;

  // up value: forward the sum written on the same edge the entry was read
  assign up_cost = fwd_r ? fwd_data_r : rd_data_r;

  always_comb begin
    if (s1_first_row_r && s1_first_col_r) begin
      base_cost = '0;
    end else if (s1_first_row_r) begin
      base_cost = left_r;
    end else if (s1_first_col_r) begin
      base_cost = up_cost;
    end else begin
      base_cost = (up_cost < left_r) ? up_cost : left_r;
    end
    sum_wide = {1'b0, base_cost} + (SUM_BITS + 1)'(s1_cost_r);
    sum      = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_W'(RESET_COLS);
      rows_r <= ROWS_W'(RESET_ROWS);
      col_r  <= '0;
      row_r  <= '0;
    end else if (cfg_restart) begin
      unique case (cfg_index)
        REG_GRID_COLS: begin
          cols_r <= COLS_W'(clamp_size(cfg_data, MAX_COLS));
          col_r  <= '0;
          row_r  <= '0;
        end
        REG_GRID_ROWS: begin
          rows_r <= ROWS_W'(clamp_size(cfg_data, MAX_ROWS));
          col_r  <= '0;
          row_r  <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + ROW_BITS'(1);
      end else begin
        col_r <= col_r + COL_BITS'(1);
      end
    end
  end

  // row memory: read at accept, write back when the cell leaves stage 1
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      row_mem[s1_col_r] <= sum;
    end
    if (in_acc) begin
      rd_data_r <= row_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cost_r      <= in_cell_cost[COST_BITS-1:0];
      s1_col_r       <= col_r;
      s1_first_row_r <= (row_r == '0);
      s1_first_col_r <= (col_r == '0);
      s1_final_r     <= last_col & last_row;
      fwd_r          <= s1_adv & (s1_col_r == col_r);
      fwd_data_r     <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (cfg_restart) begin
      left_r <= '0;
    end else if (s1_adv) begin
      left_r <= sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sum_r   <= sum;
      out_final_r <= s1_final_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_path_cost = out_sum_r;
  assign out_is_final  = out_final_r;

endmodule

FILE: sv/gmps_checker.sv
module gmps_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [gmps_pkg::SUM_BITS-1:0]     out_path_cost,
  input logic                              out_is_final
);
  import gmps_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_path_cost) && $stable(out_is_final))
    else $error("stalled result changed");

  // output is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input backs up only when a result is waiting on a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  // an accepted item reaches the output once the output frees up
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("accepted item did not reach output");

endmodule

bind grid_min_path_sum gmps_checker u_gmps_checker (.*);
